FILE: rtl/rsm_pkg.sv
// rsm_pkg: shared types and constants for the row softmax block
// holds beat structs, row sizes and the 2^-f exponent table built at elaboration
// no dependencies
package rsm_pkg;

    localparam int ROW_MAX         = 64;
    localparam int IDX_W           = $clog2(ROW_MAX);
    localparam int CNT_W           = $clog2(ROW_MAX + 1);
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int TAB_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int TOTAL_W         = 16 + CNT_W;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [16:0] EXP_LIMIT = 17'd4096;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [15:0] prob;
        logic        last_res;
        logic        overflowed;
    } res_t;

    typedef logic [16:0] exp_tab_t [EXP_TABLE_DEPTH];

    // restoring shift and subtract quotient, only used while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic exp_tab_t build_exp_table();
        exp_tab_t    tab;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            z    = (64'(i) * LN2_Q32) >> TAB_IDX_W;
            term = 64'd1 << 32;
            sum  = term;
            for (int k = 1; k <= 20; k++)
            begin
                term = udiv64((term * z) >> 32, 64'(k));
                sum  = sum + term;
            end
            tab[i] = 17'(udiv64((64'd1 << 48) + (sum >> 1), sum));
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/row_softmax.sv
// row_softmax: row-wise softmax over signed Q8.8 elements, Q0.16 results
// uses rsm_pkg for beat structs, sizes and the exponent table
// two synchronous memories hold the row and its exponentials
//
// channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------
// input    | item_valid | item_stall | item (value, last)
// result   | res_valid  | res_stall  | res (prob, last_res, overflowed)
//
// elements are taken one per cycle while a row loads; input stalls otherwise
// after the last beat: an exponent pass over each element (read,
// multiply, table and write back), then a divide pass over each element
// (read, load, 17 restoring divide steps, output), held by any result stall
// reset returns to row loading with an empty row; memories are not cleared
module row_softmax (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  rsm_pkg::item_t item,
    output logic          res_valid,
    input  logic          res_stall,
    output rsm_pkg::res_t res
);
    import rsm_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_ERD  = 4'd1;
    localparam logic [3:0] S_EMUL = 4'd2;
    localparam logic [3:0] S_EWR  = 4'd3;
    localparam logic [3:0] S_DRD  = 4'd4;
    localparam logic [3:0] S_DLD  = 4'd5;
    localparam logic [3:0] S_DIT  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [15:0] row_mem [ROW_MAX];
    logic [15:0] exp_mem [ROW_MAX];
    logic [15:0] row_rd_reg;
    logic [15:0] exp_rd_reg;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [15:0]       max_reg, max_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic                     ovf_reg, ovf_next;
    logic [21:0]              y_reg, y_next;
    logic                     far_reg, far_next;
    logic [32:0]              rem_reg, rem_next;
    logic [TOTAL_W+15:0]      div_reg, div_next;
    logic [16:0]              quo_reg, quo_next;
    logic [4:0]               bit_reg, bit_next;

    logic                     in_take;
    logic                     out_take;
    logic                     row_wr;
    logic                     exp_wr;
    logic [15:0]              exp_val;
    logic signed [16:0]       diff;
    logic [16:0]              shifted;
    logic                     is_last;
    logic                     fits;

    assign item_stall = (state_reg != S_LOAD);
    assign res_valid  = (state_reg == S_OUT);
    assign in_take    = item_valid && !item_stall;
    assign out_take   = res_valid && !res_stall;
    assign row_wr     = in_take && (cnt_reg < CNT_W'(ROW_MAX));
    assign exp_wr     = (state_reg == S_EWR);
    assign is_last    = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    assign diff    = {max_reg[15], max_reg} - {row_rd_reg[15], row_rd_reg};
    assign shifted = EXP_TABLE[y_reg[15:16-TAB_IDX_W]] >> y_reg[21:16];
    assign exp_val = far_reg ? 16'd0 : (shifted[16] ? 16'hFFFF : shifted[15:0]);
    assign fits    = {{(TOTAL_W-17){1'b0}}, rem_reg} >= div_reg;

    always_ff @(posedge clk)
    begin
        if (row_wr)
        begin
            row_mem[cnt_reg[IDX_W-1:0]] <= item.value;
        end
        row_rd_reg <= row_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr)
        begin
            exp_mem[idx_reg] <= exp_val;
        end
        exp_rd_reg <= exp_mem[idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        max_next   = max_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        y_next     = y_reg;
        far_next   = far_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (row_wr)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg == '0 || item.value > max_reg)
                        begin
                            max_next = item.value;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        idx_next   = '0;
                        total_next = '0;
                        state_next = S_ERD;
                    end
                end
            end
            S_ERD:
            begin
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                far_next   = diff > $signed({1'b0, EXP_LIMIT});
                y_next     = 22'((30'(diff[12:0]) * 30'(LOG2E_Q16)) >> 8);
                state_next = S_EWR;
            end
            S_EWR:
            begin
                total_next = total_reg + TOTAL_W'(exp_val);
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_DRD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_ERD;
                end
            end
            S_DRD:
            begin
                state_next = S_DLD;
            end
            S_DLD:
            begin
                rem_next   = {1'b0, exp_rd_reg, 16'd0} + 33'(total_reg >> 1);
                div_next   = {total_reg, 16'd0};
                quo_next   = '0;
                bit_next   = 5'd16;
                state_next = S_DIT;
            end
            S_DIT:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - div_reg[32:0];
                end
                quo_next = {quo_reg[15:0], fits};
                div_next = div_reg >> 1;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    if (is_last)
                    begin
                        cnt_next   = '0;
                        max_next   = 16'sh8000;
                        total_next = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_DRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            max_reg   <= 16'sh8000;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            max_reg   <= max_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        far_reg <= far_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign res.prob       = quo_reg[16] ? 16'hFFFF : quo_reg[15:0];
    assign res.last_res   = is_last;
    assign res.overflowed = ovf_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !item_stall |-> !res_valid)
        else $error("input open while a result is shown");

    a_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && res.last_res) |=> (!item_stall && cnt_reg == '0))
        else $error("row not cleared after final result");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROW_MAX))
        else $error("element count beyond row capacity");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cnt_reg != '0))
        else $error("result shown for an empty row");

endmodule
